// ----- hdl/dsf_pkg.sv -----
`timescale 1ns / 1ps

package dsf_pkg;

  localparam int COUNT_WIDTH_DEF = 8;
  localparam int TIME_WIDTH_DEF  = 16;

  // configuration register file
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOAK_TIME     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_TIME = 1'b1;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_TICK   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    PH_NORMAL   = 2'd0,
    PH_DEFECT   = 2'd1,
    PH_FAILURE  = 2'd2,
    PH_RECOVERY = 2'd3
  } phase_t;

  // fixed-width part of a registered request
  typedef struct packed {
    logic [1:0] op;
    logic       defect;
    logic       override;
  } dsf_ctl_t;

endpackage

// ----- hdl/dsf_if.sv -----
`timescale 1ns / 1ps

interface dsf_in_if #(
  parameter int COUNT_WIDTH = 8
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             op;
  logic                   defect_status;
  logic [COUNT_WIDTH-1:0] transition_count;
  logic                   recovery_override;

  modport source (
    output valid, op, defect_status, transition_count, recovery_override,
    input  ready
  );
  modport sink (
    input  valid, op, defect_status, transition_count, recovery_override,
    output ready
  );
endinterface

interface dsf_out_if;
  logic       valid;
  logic       ready;
  logic       failure_status;
  logic [1:0] phase;

  modport source (
    output valid, failure_status, phase,
    input  ready
  );
  modport sink (
    input  valid, failure_status, phase,
    output ready
  );
endinterface

// ----- hdl/defect_soak_failure_fsm.sv -----
`timescale 1ns / 1ps

// Defect soak and failure qualifier. Every request (defect update, 1 ms tick
// or clear) yields one result with the failure flag and phase after it. A
// request is registered on entry and the phase/timer update is combinational
// between that register and the result register, so a request can be taken
// every clock unless out_ch.ready stalls the result: one request per cycle
// sustained, set by the state update loop. The user writes soak and recovery
// times through cfg_* (index 0 soak, 1 recovery) only while the block is
// idle; the block does not enforce this. A zero time skips that soak.
module defect_soak_failure_fsm #(
  parameter int COUNT_WIDTH = dsf_pkg::COUNT_WIDTH_DEF,
  parameter int TIME_WIDTH  = dsf_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  dsf_in_if.sink                         in_ch,
  dsf_out_if.source                      out_ch
);
  import dsf_pkg::*;

  logic [CFG_DATA_W-1:0]  soak_time_r;
  logic [CFG_DATA_W-1:0]  recovery_time_r;
  logic                   item_valid;
  logic                   item_ready;
  dsf_ctl_t               item_ctl;
  logic [COUNT_WIDTH-1:0] item_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soak_time_r     <= '0;
      recovery_time_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SOAK_TIME:     soak_time_r     <= cfg_wdata;
        CFG_RECOVERY_TIME: recovery_time_r <= cfg_wdata;
      endcase
    end
  end

  dsf_in_stage #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item_ctl   (item_ctl),
    .item_count (item_count)
  );

  dsf_core #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .soak_time     (soak_time_r),
    .recovery_time (recovery_time_r),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item_ctl      (item_ctl),
    .item_count    (item_count),
    .out_ch        (out_ch)
  );

endmodule

// ----- hdl/dsf_in_stage.sv -----
`timescale 1ns / 1ps

module dsf_in_stage #(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  dsf_in_if.sink                  in_ch,
  output logic                    item_valid,
  input  logic                    item_ready,
  output dsf_pkg::dsf_ctl_t       item_ctl,
  output logic [COUNT_WIDTH-1:0]  item_count
);
  import dsf_pkg::*;

  logic                   valid_r, valid_nxt;
  dsf_ctl_t               ctl_r;
  logic [COUNT_WIDTH-1:0] count_r;
  logic                   take;

  assign in_ch.ready = !valid_r || item_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    if (take) begin
      valid_nxt = 1'b1;
    end else if (item_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ctl_r.op       <= in_ch.op;
      ctl_r.defect   <= in_ch.defect_status;
      ctl_r.override <= in_ch.recovery_override;
      count_r        <= in_ch.transition_count;
    end
  end

  assign item_valid = valid_r;
  assign item_ctl   = ctl_r;
  assign item_count = count_r;

endmodule

// ----- hdl/dsf_core.sv -----
`timescale 1ns / 1ps

module dsf_core #(
  parameter int COUNT_WIDTH = 8,
  parameter int TIME_WIDTH  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [dsf_pkg::CFG_DATA_W-1:0]  soak_time,
  input  logic [dsf_pkg::CFG_DATA_W-1:0]  recovery_time,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  dsf_pkg::dsf_ctl_t               item_ctl,
  input  logic [COUNT_WIDTH-1:0]          item_count,
  dsf_out_if.source                       out_ch
);
  import dsf_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic                   fail_r, fail_nxt;
  logic [COUNT_WIDTH-1:0] last_count_r, last_count_nxt;
  logic [TIME_WIDTH-1:0]  time_left_r, time_left_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_fail_r;
  logic [1:0]             out_phase_r;
  logic                   fire;
  logic                   changed;
  logic                   expired;
  logic [TIME_WIDTH-1:0]  soak_load;
  logic [TIME_WIDTH-1:0]  recovery_load;

  assign item_ready = !out_valid_r || out_ch.ready;
  assign fire       = item_valid && item_ready;

  assign changed       = (item_count != last_count_r);
  assign expired       = (time_left_r == '0);
  assign soak_load     = TIME_WIDTH'(soak_time);
  assign recovery_load = TIME_WIDTH'(recovery_time);

  always_comb begin
    phase_nxt      = phase_r;
    fail_nxt       = fail_r;
    last_count_nxt = last_count_r;
    time_left_nxt  = time_left_r;
    unique case (item_ctl.op)
      OP_UPDATE: begin
        last_count_nxt = item_count;
        unique case (phase_r)
          PH_NORMAL: begin
            if (item_ctl.defect) begin
              if (soak_time != '0) begin
                time_left_nxt = soak_load;
                phase_nxt     = PH_DEFECT;
              end else begin
                phase_nxt = PH_FAILURE;
                fail_nxt  = 1'b1;
              end
            end
          end
          PH_DEFECT: begin
            priority if (!item_ctl.defect) begin
              phase_nxt = PH_NORMAL;
            end else if (changed) begin
              time_left_nxt = soak_load;
            end else if (expired) begin
              phase_nxt = PH_FAILURE;
              fail_nxt  = 1'b1;
            end else begin
              // still soaking
            end
          end
          PH_FAILURE: begin
            if (!item_ctl.defect) begin
              if (recovery_time != '0) begin
                time_left_nxt = recovery_load;
                phase_nxt     = PH_RECOVERY;
              end else begin
                phase_nxt = PH_NORMAL;
                fail_nxt  = 1'b0;
              end
            end
          end
          PH_RECOVERY: begin
            // defect back before clearing: failure stays declared
            priority if (item_ctl.defect) begin
              phase_nxt = PH_FAILURE;
            end else if (changed) begin
              time_left_nxt = recovery_load;
            end else if (expired || item_ctl.override) begin
              phase_nxt = PH_NORMAL;
              fail_nxt  = 1'b0;
            end else begin
              // still waiting out the recovery time
            end
          end
        endcase
      end
      OP_TICK: begin
        if (!expired) begin
          time_left_nxt = time_left_r - TIME_WIDTH'(1);
        end
      end
      OP_CLEAR: begin
        phase_nxt      = PH_NORMAL;
        fail_nxt       = 1'b0;
        last_count_nxt = '0;
        time_left_nxt  = '0;
      end
      default: begin
        // unused code: state reported unchanged
      end
    endcase
  end

  always_comb begin
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_NORMAL;
      fail_r       <= 1'b0;
      last_count_r <= '0;
      time_left_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        phase_r      <= phase_nxt;
        fail_r       <= fail_nxt;
        last_count_r <= last_count_nxt;
        time_left_r  <= time_left_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_fail_r  <= fail_nxt;
      out_phase_r <= phase_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.failure_status = out_fail_r;
  assign out_ch.phase          = out_phase_r;

endmodule
